[hw/rtl/utf8_to_gb2312_transcoder_defines.svh]
`ifndef UTF8_TO_GB2312_TRANSCODER_DEFINES_SVH
`define UTF8_TO_GB2312_TRANSCODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define U8GB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define U8GB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/u8gb_pkg.sv]
`timescale 1ns / 1ps

package u8gb_pkg;

  localparam logic [7:0] QMARK       = 8'h3F;
  localparam logic       OP_CONVERT  = 1'b0;
  localparam logic       OP_LOAD     = 1'b1;
  localparam int         CFG_W       = 6;
  localparam int         IDX_W       = 5;
  localparam int         IN_DATA_W   = 48;
  localparam int         OUT_DATA_W  = 8;
  localparam logic [15:0] CODE_REPL  = 16'hFFFD;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_OUT    = 3'b100
  } top_state_t;

  typedef enum logic [2:0] {
    SR_IDLE  = 3'b001,
    SR_PROBE = 3'b010,
    SR_CMP   = 3'b100
  } search_state_t;

  typedef struct packed {
    logic        start;
    logic [15:0] key;
  } search_req_t;

  typedef struct packed {
    logic        done;
    logic        hit;
    logic [15:0] code;
  } search_resp_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] index;
    logic [15:0]      key;
    logic [15:0]      code;
  } table_load_t;

endpackage

[hw/rtl/utf8_to_gb2312_transcoder.sv]
`timescale 1ns / 1ps
// A byte that needs no table lookup shows its first result in the cycle after its
// transfer; a lookup passes the sreq register, then each binary-search probe runs SR_PROBE
// (registered table read) and SR_CMP, and a miss closes with a final SR_PROBE (at most 6
// probes at 32 entries). A new item is taken only in ST_IDLE, after the search and all
// output bytes of the last item; load items are written as accepted and yield no output.
// Reset (rst, synchronous, active high) clears held bytes, entry_count and the sequencer;
// table contents are undefined until loaded.
`include "utf8_to_gb2312_transcoder_defines.svh"

module utf8_to_gb2312_transcoder import u8gb_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data,     // entry_count
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,      // in_byte, entry_index, entry_code, entry_gb
  input  logic                  s_tlast,      // message_end
  input  logic                  s_tuser,      // operation
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,      // out_byte
  output logic                  m_tlast,      // run_last
  output logic                  m_tuser       // message_done
);

  typedef struct packed {
    logic       emit;
    logic       hold;
    logic [7:0] val;
  } lead_t;

  function automatic lead_t take_lead(input logic [7:0] b);
    lead_t r;
    r = '0;
    if (!b[7]) begin
      r.emit = 1'b1;
      r.val  = b;
    end else if ((b[7:5] == 3'b110) || (b[7:4] == 4'b1110)) begin
      r.hold = 1'b1;
    end else begin
      r.emit = 1'b1;
      r.val  = QMARK;
    end
    return r;
  endfunction

  top_state_t         state;
  logic [CFG_W-1:0]   entry_count;
  logic [7:0]         held_lead;
  logic [7:0]         held_cont;
  logic [1:0]         held_count;
  logic [2:0][7:0]    q;
  logic [1:0]         qn;
  logic [1:0]         optr;
  logic               end_flag;
  search_req_t        sreq;
  search_resp_t       sresp;
  table_load_t        load;

  logic               in_xfer;
  logic               out_xfer;
  logic               out_last;
  logic [7:0]         b_in;

  logic [2:0][7:0]    q_next;
  logic [1:0]         qn_next;
  logic [7:0]         lead_next;
  logic [7:0]         cont_next;
  logic [1:0]         count_next;
  logic               need_search;
  logic [15:0]        code_next;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign b_in      = s_tdata[7:0];

  assign load.en    = in_xfer && (s_tuser == OP_LOAD);
  assign load.index = s_tdata[12:8];
  assign load.key   = s_tdata[28:13];
  assign load.code  = s_tdata[44:29];

  always_comb begin
    lead_t      tl;
    logic       have_code;
    logic       cont_ok;
    q_next      = '0;
    qn_next     = '0;
    lead_next   = held_lead;
    cont_next   = held_cont;
    count_next  = held_count;
    need_search = 1'b0;
    code_next   = '0;
    have_code   = 1'b0;
    tl          = '0;
    cont_ok     = (b_in[7:6] == 2'b10);

    if (held_count == 2'd0) begin
      tl = take_lead(b_in);
    end else if (!cont_ok) begin
      q_next[qn_next] = QMARK;
      qn_next = qn_next + 2'd1;
      if (held_count >= 2'd2) begin
        q_next[qn_next] = QMARK;
        qn_next = qn_next + 2'd1;
      end
      lead_next  = '0;
      cont_next  = '0;
      count_next = '0;
      tl = take_lead(b_in);
    end else if (held_lead[7:5] == 3'b110) begin
      code_next  = {5'd0, held_lead[4:0], b_in[5:0]};
      have_code  = 1'b1;
      lead_next  = '0;
      cont_next  = '0;
      count_next = '0;
    end else if (held_count == 2'd1) begin
      cont_next  = b_in;
      count_next = 2'd2;
    end else begin
      code_next  = {held_lead[3:0], held_cont[5:0], b_in[5:0]};
      have_code  = 1'b1;
      lead_next  = '0;
      cont_next  = '0;
      count_next = '0;
    end

    if (tl.emit && (qn_next < 2'd3)) begin
      q_next[qn_next] = tl.val;
      qn_next = qn_next + 2'd1;
    end
    if (tl.hold) begin
      lead_next  = b_in;
      count_next = 2'd1;
    end

    if (have_code) begin
      if (code_next[15:7] == 9'd0) begin
        q_next[0] = code_next[7:0];
        qn_next   = 2'd1;
      end else if (code_next == CODE_REPL) begin
        q_next[0] = QMARK;
        qn_next   = 2'd1;
      end else begin
        need_search = 1'b1;
      end
    end

    // flush one '?' per byte still held at message end
    if (s_tlast) begin
      if ((count_next >= 2'd1) && (qn_next < 2'd3)) begin
        q_next[qn_next] = QMARK;
        qn_next = qn_next + 2'd1;
      end
      if ((count_next >= 2'd2) && (qn_next < 2'd3)) begin
        q_next[qn_next] = QMARK;
        qn_next = qn_next + 2'd1;
      end
      lead_next  = '0;
      cont_next  = '0;
      count_next = '0;
    end
  end

  u8gb_search #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_search (
    .clk         (clk),
    .rst         (rst),
    .entry_count (entry_count),
    .load        (load),
    .req         (sreq),
    .resp        (sresp)
  );

  assign m_tvalid = (state == ST_OUT);
  assign out_last = (optr == (qn - 2'd1));
  assign m_tdata  = q[optr];
  assign m_tlast  = out_last;
  assign m_tuser  = out_last && end_flag;
  assign out_xfer = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      held_lead   <= '0;
      held_cont   <= '0;
      held_count  <= '0;
      qn          <= '0;
      optr        <= '0;
      end_flag    <= 1'b0;
      sreq        <= '0;
    end else begin
      sreq.start <= in_xfer && (s_tuser == OP_CONVERT) && need_search;
      if (cfg_valid && cfg_ready) begin
        entry_count <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer && (s_tuser == OP_CONVERT)) begin
            held_lead  <= lead_next;
            held_cont  <= cont_next;
            held_count <= count_next;
            q          <= q_next;
            qn         <= qn_next;
            optr       <= '0;
            end_flag   <= s_tlast;
            if (need_search) begin
              sreq.key   <= code_next;
              state      <= ST_SEARCH;
            end else if (qn_next != 2'd0) begin
              state <= ST_OUT;
            end
          end
        end
        ST_SEARCH: begin
          if (sresp.done) begin
            if (sresp.hit && (sresp.code != 16'd0)) begin
              q[0] <= sresp.code[15:8];
              q[1] <= sresp.code[7:0];
              qn   <= 2'd2;
            end else begin
              q[0] <= QMARK;
              qn   <= 2'd1;
            end
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_xfer) begin
            if (out_last) begin
              state <= ST_IDLE;
            end else begin
              optr <= optr + 2'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `U8GB_ASSERT_NOW(a_no_accept_while_out, clk, rst, m_tvalid, !s_tready, "input taken while output pending")
  `U8GB_ASSERT_NEXT(a_last_ends_run, clk, rst, out_xfer && m_tlast, !m_tvalid, "output continues after last")
  `U8GB_ASSERT_NOW(a_held_range, clk, rst, 1'b1, held_count != 2'd3, "held byte count out of range")
  `U8GB_ASSERT_NOW(a_done_in_search, clk, rst, sresp.done, state == ST_SEARCH, "search result outside search")

endmodule

[hw/rtl/u8gb_search.sv]
`timescale 1ns / 1ps

module u8gb_search import u8gb_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [CFG_W-1:0]   entry_count,
  input  table_load_t        load,
  input  search_req_t        req,
  output search_resp_t       resp
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [15:0] key_mem  [TABLE_DEPTH];
  logic [15:0] code_mem [TABLE_DEPTH];

  search_state_t state;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi_end;
  logic [AW-1:0] mid;
  logic [15:0]   key;
  logic [15:0]   rd_key;
  logic [15:0]   rd_code;

  logic [CW-1:0] n_eff;
  logic [CW:0]   mid_sum;
  logic [AW-1:0] probe_idx;
  logic          empty_range;
  logic          match;

  assign n_eff = (32'(entry_count) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(entry_count);
  // lo + hi with hi = hi_end - 1; only used while lo < hi_end
  assign mid_sum     = {1'b0, lo} + {1'b0, hi_end} - {{CW{1'b0}}, 1'b1};
  assign probe_idx   = AW'(mid_sum >> 1);
  assign empty_range = (lo >= hi_end);
  assign match       = (rd_key == key);

  always_ff @(posedge clk) begin
    if (load.en && (32'(load.index) < TABLE_DEPTH)) begin
      key_mem[AW'(load.index)]  <= load.key;
      code_mem[AW'(load.index)] <= load.code;
    end
    if (state == SR_PROBE) begin
      rd_key  <= key_mem[probe_idx];
      rd_code <= code_mem[probe_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= SR_IDLE;
      lo     <= '0;
      hi_end <= '0;
    end else begin
      case (state)
        SR_IDLE: begin
          if (req.start) begin
            key    <= req.key;
            lo     <= '0;
            hi_end <= n_eff;
            state  <= SR_PROBE;
          end
        end
        SR_PROBE: begin
          mid <= probe_idx;
          if (empty_range) begin
            state <= SR_IDLE;
          end else begin
            state <= SR_CMP;
          end
        end
        SR_CMP: begin
          if (match) begin
            state <= SR_IDLE;
          end else begin
            if (rd_key < key) begin
              lo <= CW'({1'b0, mid} + 1'b1);
            end else begin
              hi_end <= CW'(mid);
            end
            state <= SR_PROBE;
          end
        end
        default: state <= SR_IDLE;
      endcase
    end
  end

  assign resp.done = ((state == SR_PROBE) && empty_range) || ((state == SR_CMP) && match);
  assign resp.hit  = (state == SR_CMP) && match;
  assign resp.code = rd_code;

endmodule
